// ===== hw/rtl/wua_pkg.sv =====
package wua_pkg;

    // Port data width; the operand width parameter may be narrower.
    localparam int DATA_W    = 64;
    localparam int WIDTH_DEF = 64;
    localparam int ACT_W     = 4;
    localparam int ERR_W     = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_MUL = 4'd2,
        ACT_DIV = 4'd3,
        ACT_MOD = 4'd4,
        ACT_CMP = 4'd5,
        ACT_AND = 4'd6,
        ACT_OR  = 4'd7,
        ACT_NOT = 4'd8,
        ACT_SHL = 4'd9,
        ACT_SHR = 4'd10
    } t_act;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_OVF  = 2'd1,
        ERR_UNF  = 2'd2,
        ERR_DIV0 = 2'd3
    } t_err;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic              gt;
        logic              eq;
        t_err              err;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] divisor;
    } t_stage;

endpackage

// ===== hw/rtl/wua_front.sv =====
module wua_front import wua_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ACT_W-1:0]  i_act,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_valid,
    output t_stage            o_stage
);

    localparam int ALIGN = DATA_W - WIDTH;

    logic [DATA_W-1:0] w_mask;
    logic [DATA_W:0]   w_sum;
    logic              r_valid;
    t_stage            r_stage;
    t_stage            n_stage;

    assign w_mask = {DATA_W{1'b1}} >> ALIGN;
    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};

    // Decode the action and compute every single-cycle result.
    always_comb begin
        n_stage         = '0;
        n_stage.act     = i_act;
        n_stage.gt      = (i_a > i_b);
        n_stage.eq      = (i_a == i_b);
        n_stage.err     = ERR_OK;
        n_stage.quo     = i_a << ALIGN;
        n_stage.divisor = i_b;
        case (t_act'(i_act))
            ACT_ADD: begin
                n_stage.res = w_sum[DATA_W-1:0] & w_mask;
                if ((w_sum >> WIDTH) != '0) n_stage.err = ERR_OVF;
            end
            ACT_SUB: begin
                n_stage.res = (i_a - i_b) & w_mask;
                if (i_a < i_b) n_stage.err = ERR_UNF;
            end
            ACT_DIV, ACT_MOD: begin
                if (i_b == '0) n_stage.err = ERR_DIV0;
            end
            ACT_AND: n_stage.res = i_a & i_b;
            ACT_OR:  n_stage.res = i_a | i_b;
            ACT_NOT: n_stage.res = ~i_a & w_mask;
            ACT_SHL: begin
                if (i_b < DATA_W'(WIDTH)) n_stage.res = (i_a << i_b[5:0]) & w_mask;
            end
            ACT_SHR: begin
                if (i_b < DATA_W'(WIDTH)) n_stage.res = i_a >> i_b[5:0];
            end
            default: n_stage.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/wua_mul.sv =====
module wua_mul import wua_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DATA_W-1:0]   i_a,
    input  logic [DATA_W-1:0]   i_b,
    output logic [2*DATA_W-1:0] o_prod
);

    localparam int HW = DATA_W / 2;

    logic [DATA_W-1:0]   r_ll;
    logic [DATA_W-1:0]   r_lh;
    logic [DATA_W-1:0]   r_hl;
    logic [DATA_W-1:0]   r_hh;
    logic [2*DATA_W-1:0] r_prod;

    // First stage: four half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[HW-1:0]      * i_b[HW-1:0];
            r_lh <= i_a[HW-1:0]      * i_b[DATA_W-1:HW];
            r_hl <= i_a[DATA_W-1:HW] * i_b[HW-1:0];
            r_hh <= i_a[DATA_W-1:HW] * i_b[DATA_W-1:HW];
        end
    end

    // Second stage: align and sum the partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{DATA_W{1'b0}}, r_ll}
                    + {{HW{1'b0}}, r_lh, {HW{1'b0}}}
                    + {{HW{1'b0}}, r_hl, {HW{1'b0}}}
                    + {r_hh, {DATA_W{1'b0}}};
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/wua_div_stage.sv =====
module wua_div_stage import wua_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_valid,
    output t_stage o_stage
);

    logic [DATA_W:0] w_trial;
    logic            w_fit;
    logic            r_valid;
    t_stage          r_stage;
    t_stage          n_stage;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign w_trial = {i_stage.rem, i_stage.quo[DATA_W-1]};
    assign w_fit   = (w_trial >= {1'b0, i_stage.divisor});

    always_comb begin
        n_stage     = i_stage;
        n_stage.quo = {i_stage.quo[DATA_W-2:0], w_fit};
        if (w_fit) begin
            n_stage.rem = DATA_W'(w_trial - {1'b0, i_stage.divisor});
        end else begin
            n_stage.rem = w_trial[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/wide_unsigned_alu_unit.sv =====
// Wide unsigned ALU, fully pipelined.
// Input stream: tuser carries the action code, tdata carries operand_a in
// the low 64 bits and operand_b in the high 64 bits. Operands are used at
// WIDTH bits. Output stream: tdata is result_value; tuser carries
// a_greater, a_equal and error_code from the lowest bit up.
// Every item yields exactly one result transfer, in input order.
// The path from input transfer to output valid is one decode stage, WIDTH
// restoring-division steps (one quotient bit each) and the output register.
// The two-stage multiplier runs beside the first division steps. One item
// is accepted per cycle while the pipeline is not held.
// When a finished result waits and the receiver stalls, the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated. Synchronous
// active-low reset clears every valid bit; data registers are not reset.
module wide_unsigned_alu_unit import wua_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [2*DATA_W-1:0] i_s_axis_tdata,  // operand_a, operand_b
    input  logic [ACT_W-1:0]    i_s_axis_tuser,  // action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [DATA_W-1:0]   o_m_axis_tdata,  // result_value
    output logic [3:0]          o_m_axis_tuser   // a_greater, a_equal, error_code
);

    localparam int ALIGN = DATA_W - WIDTH;

    logic [DATA_W-1:0]   w_mask;
    logic [DATA_W-1:0]   w_a;
    logic [DATA_W-1:0]   w_b;
    logic                w_en;
    logic [2*DATA_W-1:0] w_prod;
    logic                v [0:WIDTH];
    t_stage              s [0:WIDTH];
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic [3:0]          r_out_user;
    logic [DATA_W-1:0]   n_out_data;

    assign w_mask = {DATA_W{1'b1}} >> ALIGN;
    assign w_a    = i_s_axis_tdata[DATA_W-1:0] & w_mask;
    assign w_b    = i_s_axis_tdata[2*DATA_W-1:DATA_W] & w_mask;

    // The pipeline advances unless a finished result is still waiting.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    wua_front #(.WIDTH(WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_act   (i_s_axis_tuser),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_valid (v[0]),
        .o_stage (s[0])
    );

    wua_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Division steps; the product joins its item on the way into stage two.
    for (genvar k = 1; k <= WIDTH; k++) begin : g_div
        t_stage w_in;

        always_comb begin
            w_in = s[k-1];
            if (k == 2 && s[k-1].act == ACT_MUL) begin
                w_in.res = w_prod[DATA_W-1:0] & w_mask;
                w_in.err = ((w_prod >> WIDTH) != '0) ? ERR_OVF : ERR_OK;
            end
        end

        wua_div_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (v[k-1]),
            .i_stage (w_in),
            .o_valid (v[k]),
            .o_stage (s[k])
        );
    end

    // Pick the final value for the item leaving the last division step.
    always_comb begin
        if (s[WIDTH].err == ERR_DIV0) begin
            n_out_data = '0;
        end else if (s[WIDTH].act == ACT_DIV) begin
            n_out_data = s[WIDTH].quo & w_mask;
        end else if (s[WIDTH].act == ACT_MOD) begin
            n_out_data = s[WIDTH].rem;
        end else begin
            n_out_data = s[WIDTH].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= v[WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_user <= {s[WIDTH].err, s[WIDTH].eq, s[WIDTH].gt};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    // A held result keeps its payload while the pipeline is frozen.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !w_en) |=> ($stable(r_out_data) && $stable(r_out_user)))
        else $error("held result changed during stall");

    // Greater and equal are exclusive.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("greater and equal both set");

    // Underflow only when operand_a is below operand_b.
    a_unf_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3:2] == ERR_UNF)
            |-> (!o_m_axis_tuser[0] && !o_m_axis_tuser[1]))
        else $error("underflow with a not below b");

    // Division by zero always returns zero.
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3:2] == ERR_DIV0) |-> (o_m_axis_tdata == '0))
        else $error("divide by zero with nonzero result");
`endif

endmodule
